[rtl/core/mmst_pkg.sv]
// Shared types and constants of the min/max contrast stretch block.
package mmst_pkg;

  localparam int IDX_W            = 12;
  localparam int SAMPLE_W         = 16;
  localparam int BYTE_W           = 8;
  localparam int CFG_W            = 16;
  localparam int FRAME_PIXELS_DEF = 4096;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_EXPOSURE = 2'd0;
  localparam logic [1:0] REG_OFFSET   = 2'd1;
  localparam logic [1:0] REG_GAIN     = 2'd2;

  localparam logic [CFG_W-1:0] EXPOSURE_RST = 16'd256;
  localparam logic [CFG_W-1:0] OFFSET_RST   = 16'd0;
  localparam logic [CFG_W-1:0] GAIN_RST     = 16'd256;

  // Full scale of the stretched pixel in Q8.8 (255 * 256).
  localparam int SCALE = 65280;
  // Clamp window for the value entering the gain multiply.
  localparam int X_MIN = -1;
  localparam int X_MAX = 16711680;
  localparam int T_MAX = 65280;

  // Divider geometry: magnitude of (v - min) * SCALE and max - min.
  localparam int NUM_W = 32;
  localparam int DEN_W = 16;

  typedef struct packed {
    logic [CFG_W-1:0] exposure;
    logic [CFG_W-1:0] offset;
    logic [CFG_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_cmd_t;

endpackage

[rtl/core/mmst_if.sv]
// Valid/ready channel interfaces for input items and result beats.
interface mmst_item_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [mmst_pkg::IDX_W-1:0]       pixel_index;
  logic signed [mmst_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, kind, pixel_index, sample, input ready);
  modport sink   (input valid, kind, pixel_index, sample, output ready);
endinterface

interface mmst_result_if;
  logic                        valid;
  logic                        ready;
  logic [mmst_pkg::BYTE_W-1:0] pixel_byte;
  logic [mmst_pkg::IDX_W-1:0]  out_index;

  modport source (output valid, pixel_byte, out_index, input ready);
  modport sink   (input valid, pixel_byte, out_index, output ready);
endinterface

[rtl/core/mmst_cfg.sv]
// APB register file for exposure, offset and gain.
module mmst_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmst_pkg::PADDR_W-1:0]  paddr,
  input  logic [mmst_pkg::PDATA_W-1:0]  pwdata,
  output logic [mmst_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output mmst_pkg::cfg_t                cfg
);

  logic [1:0] reg_sel;
  logic       wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exposure <= mmst_pkg::EXPOSURE_RST;
      cfg.offset   <= mmst_pkg::OFFSET_RST;
      cfg.gain     <= mmst_pkg::GAIN_RST;
    end else if (wr) begin
      unique case (reg_sel)
        mmst_pkg::REG_EXPOSURE: cfg.exposure <= pwdata[mmst_pkg::CFG_W-1:0];
        mmst_pkg::REG_OFFSET:   cfg.offset   <= pwdata[mmst_pkg::CFG_W-1:0];
        mmst_pkg::REG_GAIN:     cfg.gain     <= pwdata[mmst_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mmst_pkg::REG_EXPOSURE: prdata = mmst_pkg::PDATA_W'(cfg.exposure);
      mmst_pkg::REG_OFFSET:   prdata = mmst_pkg::PDATA_W'(cfg.offset);
      mmst_pkg::REG_GAIN:     prdata = mmst_pkg::PDATA_W'(cfg.gain);
      default:                prdata = '0;
    endcase
  end

endmodule

[rtl/core/mmst_store.sv]
// Frame memory with a registered read port and the running frame min/max.
module mmst_store #(
  parameter int FRAME_PIXELS = mmst_pkg::FRAME_PIXELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mmst_pkg::store_cmd_t                 cmd,
  input  logic [mmst_pkg::IDX_W-1:0]           idx,
  input  logic signed [mmst_pkg::SAMPLE_W-1:0] sample,
  output logic signed [mmst_pkg::SAMPLE_W-1:0] rd_data,
  output logic signed [mmst_pkg::SAMPLE_W-1:0] fmin,
  output logic signed [mmst_pkg::SAMPLE_W-1:0] fmax
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  logic [mmst_pkg::SAMPLE_W-1:0]   mem [FRAME_PIXELS];
  logic [mmst_pkg::IDX_W+AW-1:0]   idx_ext;
  logic [AW-1:0]                   addr;

  assign idx_ext = {{AW{1'b0}}, idx};
  assign addr    = idx_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= sample;
    end
    if (cmd.rd_en) begin
      rd_data <= $signed(mem[addr]);
    end
  end

  // A load at index zero opens a new frame; other loads only widen the range.
  always_ff @(posedge clk) begin
    if (rst) begin
      fmin <= '0;
      fmax <= '0;
    end else if (cmd.wr_en) begin
      if (idx == '0) begin
        fmin <= sample;
        fmax <= sample;
      end else begin
        if (sample < fmin) fmin <= sample;
        if (sample > fmax) fmax <= sample;
      end
    end
  end

endmodule

[rtl/core/mmst_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module mmst_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mmst_pkg::NUM_W-1:0] num,
  input  logic [mmst_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [mmst_pkg::NUM_W-1:0] quo,
  output logic                       rem_nz
);

  localparam int CW = $clog2(mmst_pkg::NUM_W + 1);

  logic                       busy;
  logic [CW-1:0]              cnt;
  logic [mmst_pkg::DEN_W-1:0] rem;
  logic [mmst_pkg::DEN_W-1:0] dvs;
  logic [mmst_pkg::DEN_W:0]   trial;
  logic                       fits;

  assign trial  = {rem, quo[mmst_pkg::NUM_W-1]};
  assign fits   = trial >= {1'b0, dvs};
  assign rem_nz = rem != '0;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? mmst_pkg::DEN_W'(trial - {1'b0, dvs})
                  : trial[mmst_pkg::DEN_W-1:0];
      quo <= {quo[mmst_pkg::NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(mmst_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/minmax_stretch_to_byte_unit.sv]
// Top level of the min/max contrast stretch to one byte per pixel.
//
//   channel   dir  handshake      beat contents
//   item      in   valid/ready    kind, pixel_index, sample
//   result    out  valid/ready    pixel_byte, out_index
//   apb       in   psel/penable   exposure, offset, gain
//
// A load beat is taken while the sequencer is idle, and loads may follow each other every cycle.
// A readout runs from its accept through a numerator state on the fresh memory read,
// the bit-serial divider (32 quotient steps, then its done strobe), then multiply,
// offset, multiply and output; the next item is accepted once the output state is left.
// A flat frame or an index beyond the frame skips the divider. The result sits in an
// output register; the next item is taken while it waits.
// Reset is synchronous and clears the control state, min/max and the configuration registers.
// A stalled result holds the sequencer in its last state until the beat leaves.
module minmax_stretch_to_byte_unit #(
  parameter int FRAME_PIXELS = mmst_pkg::FRAME_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  mmst_item_if.sink                    item,
  mmst_result_if.source                result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mmst_pkg::PADDR_W-1:0] paddr,
  input  logic [mmst_pkg::PDATA_W-1:0] pwdata,
  output logic [mmst_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int P_W  = mmst_pkg::NUM_W + 1;
  localparam int M1_W = P_W + mmst_pkg::CFG_W + 1;
  localparam int X_W  = 25;
  localparam int M2_W = X_W + mmst_pkg::CFG_W + 1;

  mmst_pkg::cfg_t       cfg;
  mmst_pkg::store_cmd_t cmd;

  logic [2:0] state;
  logic [2:0] state_next;

  logic accept;
  logic in_rng;
  logic out_free;

  logic [mmst_pkg::IDX_W-1:0]           idx_q;
  logic                                 rng_q;
  logic                                 neg;
  logic signed [mmst_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [mmst_pkg::SAMPLE_W-1:0] fmin;
  logic signed [mmst_pkg::SAMPLE_W-1:0] fmax;

  logic signed [mmst_pkg::SAMPLE_W:0]   diff;
  logic signed [mmst_pkg::SAMPLE_W:0]   span;
  logic [mmst_pkg::SAMPLE_W:0]          absd;
  logic [mmst_pkg::NUM_W-1:0]           mag;
  logic                                 div_start;
  logic                                 div_done;
  logic [mmst_pkg::NUM_W-1:0]           div_q;
  logic                                 div_rnz;

  logic signed [P_W-1:0]  p;
  logic signed [M1_W-1:0] prod1;
  logic signed [M1_W-1:0] sum;
  logic signed [X_W-1:0]  xc;
  logic signed [M2_W-1:0] prod2;
  logic signed [M2_W-1:0] t;
  logic [15:0]            tc;

  logic                           out_valid;
  logic [mmst_pkg::BYTE_W-1:0]    out_byte;
  logic [mmst_pkg::IDX_W-1:0]     out_idx;

  mmst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid & item.ready;
  assign in_rng     = {{(32 - mmst_pkg::IDX_W){1'b0}}, item.pixel_index} < 32'(FRAME_PIXELS);

  assign cmd.wr_en = accept & ~item.kind & in_rng;
  assign cmd.rd_en = accept & item.kind;

  mmst_store #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .idx     (item.pixel_index),
    .sample  (item.sample),
    .rd_data (rd_data),
    .fmin    (fmin),
    .fmax    (fmax)
  );

  // Numerator magnitude and divisor, taken from the fresh memory read.
  assign diff = (mmst_pkg::SAMPLE_W + 1)'(rd_data) - (mmst_pkg::SAMPLE_W + 1)'(fmin);
  assign span = (mmst_pkg::SAMPLE_W + 1)'(fmax) - (mmst_pkg::SAMPLE_W + 1)'(fmin);
  assign absd = diff[mmst_pkg::SAMPLE_W] ? (mmst_pkg::SAMPLE_W + 1)'(-diff)
                                         : (mmst_pkg::SAMPLE_W + 1)'(diff);
  assign mag  = mmst_pkg::NUM_W'(absd) * mmst_pkg::NUM_W'(mmst_pkg::SCALE);

  assign div_start = (state == S_NUM) & rng_q & (span != '0);

  mmst_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (mag),
    .den    (span[mmst_pkg::DEN_W-1:0]),
    .done   (div_done),
    .quo    (div_q),
    .rem_nz (div_rnz)
  );

  // Beyond these bounds the gain stage clamps to the same byte either way.
  assign sum = (prod1 >>> 8) + M1_W'($signed(cfg.offset));
  assign t   = prod2 >>> 8;

  always_comb begin
    if (t < 0) begin
      tc = '0;
    end else if (t > M2_W'(mmst_pkg::T_MAX)) begin
      tc = 16'(mmst_pkg::T_MAX);
    end else begin
      tc = t[15:0];
    end
  end

  assign out_free = ~out_valid | result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && item.kind) state_next = S_NUM;
      S_NUM:  state_next = div_start ? S_DIV : S_MUL1;
      S_DIV:  if (div_done) state_next = S_MUL1;
      S_MUL1: state_next = S_ADD;
      S_ADD:  state_next = S_MUL2;
      S_MUL2: state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q <= item.pixel_index;
      rng_q <= in_rng;
    end
    if (state == S_NUM) begin
      neg <= diff[mmst_pkg::SAMPLE_W];
      if (!div_start) begin
        p <= '0;
      end
    end
    // The divider works on magnitudes; floor of a negative quotient rounds away.
    if (state == S_DIV && div_done) begin
      p <= neg ? -(P_W'(div_q) + P_W'(div_rnz)) : P_W'(div_q);
    end
    if (state == S_MUL1) begin
      prod1 <= M1_W'(p) * M1_W'($signed({1'b0, cfg.exposure}));
    end
    if (state == S_ADD) begin
      if (sum < M1_W'(mmst_pkg::X_MIN)) begin
        xc <= X_W'(mmst_pkg::X_MIN);
      end else if (sum > M1_W'(mmst_pkg::X_MAX)) begin
        xc <= X_W'(mmst_pkg::X_MAX);
      end else begin
        xc <= sum[X_W-1:0];
      end
    end
    if (state == S_MUL2) begin
      prod2 <= M2_W'(xc) * M2_W'($signed({1'b0, cfg.gain}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_byte <= rng_q ? tc[15:8] : '0;
      out_idx  <= idx_q;
    end
  end

  assign result.valid      = out_valid;
  assign result.pixel_byte = out_byte;
  assign result.out_index  = out_idx;

endmodule

[tb/tb.sv]
// Self-checking testbench of the min/max contrast stretch block.
`timescale 1ns / 1ps

module tb;
  import mmst_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam int FRAME_N = FRAME_PIXELS_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic                       kind;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] sample;
  } pixel_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic [IDX_W-1:0]  out_index;
  } byte_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  mmst_item_if   item_ch();
  mmst_result_if res_ch();

  minmax_stretch_to_byte_unit dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the block's state as seen through accepted beats.
  logic signed [SAMPLE_W-1:0] frame_copy [FRAME_N];
  logic signed [SAMPLE_W-1:0] lo_sample = '0;
  logic signed [SAMPLE_W-1:0] hi_sample = '0;
  logic [CFG_W-1:0]           exp_q88 = EXPOSURE_RST;
  logic signed [CFG_W-1:0]    ofs_q88 = OFFSET_RST;
  logic [CFG_W-1:0]           gain_q88 = GAIN_RST;

  byte_beat_t  byte_due [$];
  pixel_item_t pending_items [$];
  pixel_item_t next_item;

  // Stimulus bookkeeping, so that only written entries are ever read out.
  bit was_written [FRAME_N];
  int written_list [$];
  int frame_idx [$];
  int items_queued = 0;

  int item_beats = 0;
  int item_issued = 0;
  int gap_left = 0;
  int src_calm = 0;
  int stall_left = 0;
  int sink_calm = 0;
  int quiet = 0;
  int fail_count = 0;
  bit active;

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  function automatic logic [BYTE_W-1:0] stretch_to_byte(input logic signed [SAMPLE_W-1:0] v);
    longint span, p, t;
    span = longint'(hi_sample) - longint'(lo_sample);
    p = 0;
    if (span > 0) p = floor_div((longint'(v) - longint'(lo_sample)) * SCALE, span);
    t = floor_div(p * longint'(exp_q88), 256);
    t = floor_div((t + longint'(ofs_q88)) * longint'(gain_q88), 256);
    if (t < 0) t = 0;
    if (t > T_MAX) t = T_MAX;
    return t[15:8];
  endfunction

  // A 12-bit index never reaches past the frame at the default size.
  task automatic take_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] s);
    byte_beat_t want;
    if (kind == KIND_LOAD) begin
      frame_copy[idx] = s;
      if (idx == 0) begin
        lo_sample = s;
        hi_sample = s;
      end else begin
        if (s < lo_sample) lo_sample = s;
        if (s > hi_sample) hi_sample = s;
      end
    end else begin
      want.pixel_byte = stretch_to_byte(frame_copy[idx]);
      want.out_index = idx;
      byte_due.push_back(want);
    end
  endtask

  task automatic check_result(input logic [BYTE_W-1:0] got_byte,
                              input logic [IDX_W-1:0] got_idx);
    byte_beat_t want;
    if (byte_due.size() == 0) begin
      $error("unexpected result beat: pixel_byte %0d out_index %0d", got_byte, got_idx);
      fail_count++;
    end else begin
      want = byte_due.pop_front();
      if (got_byte !== want.pixel_byte) begin
        $error("pixel_byte: expected %0d, actual %0d (index %0d)",
               want.pixel_byte, got_byte, want.out_index);
        fail_count++;
      end
      if (got_idx !== want.out_index) begin
        $error("out_index: expected %0d, actual %0d", want.out_index, got_idx);
        fail_count++;
      end
    end
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      active = 1'b0;
      // Results are checked before the same edge's item adds a new expectation.
      if (res_ch.valid && res_ch.ready) begin
        check_result(res_ch.pixel_byte, res_ch.out_index);
        active = 1'b1;
      end
      if (item_ch.valid && item_ch.ready) begin
        take_item(item_ch.kind, item_ch.pixel_index, item_ch.sample);
        item_beats++;
        active = 1'b1;
      end
      quiet = active ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Item driver: a new beat goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (item_beats == item_issued) begin
      if (src_calm > 0) src_calm--;
      else if ($urandom_range(0, 149) == 0) src_calm = $urandom_range(40, 200);
      if (gap_left > 0) begin
        item_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.kind <= next_item.kind;
        item_ch.pixel_index <= next_item.idx;
        item_ch.sample <= next_item.sample;
        item_issued++;
        gap_left = (src_calm > 0) ? 0 : idle_len();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 199) == 0) sink_calm = $urandom_range(50, 300);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = (sink_calm > 0) ? 0 : idle_len();
      end
    end
  end

  task automatic push_load(input logic [IDX_W-1:0] idx, input logic signed [SAMPLE_W-1:0] s);
    pending_items.push_back('{kind: KIND_LOAD, idx: idx, sample: s});
    items_queued++;
    if (!was_written[idx]) begin
      was_written[idx] = 1'b1;
      written_list.push_back(int'(idx));
    end
    if (idx == 0) frame_idx.delete();
    frame_idx.push_back(int'(idx));
  endtask

  task automatic push_read(input logic [IDX_W-1:0] idx);
    pending_items.push_back('{kind: KIND_READ, idx: idx, sample: SAMPLE_W'($urandom)});
    items_queued++;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 1) == 0) return IDX_W'($urandom_range(0, FRAME_N - 1));
    return IDX_W'($urandom_range(1, 63));
  endfunction

  // One frame: a start load, loads within a chosen range, then mostly readouts.
  task automatic queue_frame();
    int spread, base, n, pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) spread = 0;
    else if (pick < 4) spread = $urandom_range(1, 16);
    else if (pick < 7) spread = $urandom_range(17, 4000);
    else spread = $urandom_range(4001, 65535);
    base = -32768 + int'($urandom_range(0, 65535 - spread));
    push_load(IDX_W'(0), SAMPLE_W'(base));
    n = $urandom_range(1, 24);
    repeat (n) push_load(pick_index(), SAMPLE_W'(base + int'($urandom_range(0, spread))));
    n = $urandom_range(2, 24);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        push_read(IDX_W'(frame_idx[$urandom_range(0, frame_idx.size() - 1)]));
      else if (pick < 16)
        push_read(IDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]));
      else
        push_load(pick_index(), SAMPLE_W'(base + int'($urandom_range(0, spread))));
    end
  endtask

  task automatic queue_noise();
    if ($urandom_range(0, 1) == 0)
      push_load(IDX_W'($urandom_range(0, FRAME_N - 1)), SAMPLE_W'($urandom));
    else
      push_read(IDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]));
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_beats != item_issued || byte_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_sel, input logic [CFG_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {{(PDATA_W - CFG_W){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_sel)
      REG_EXPOSURE: exp_q88 = value;
      REG_OFFSET:   ofs_q88 = value;
      REG_GAIN:     gain_q88 = value;
      default: ;
    endcase
  endtask

  initial begin
    logic [CFG_W-1:0] exp_set [N_PHASES];
    logic [CFG_W-1:0] ofs_set [N_PHASES];
    logic [CFG_W-1:0] gain_set [N_PHASES];
    int goal;

    exp_set  = '{16'd0,     16'hFFFF, 16'hFFFF, 16'd512,  16'd128,  16'd0, 16'd256};
    ofs_set  = '{16'h8000,  16'h7FFF, 16'h8000, 16'hCE00, 16'h1900, 16'd0, 16'd0};
    gain_set = '{16'd0,     16'hFFFF, 16'hFFFF, 16'd384,  16'd256,  16'd0, 16'd256};

    item_ch.valid = 1'b0;
    item_ch.kind = KIND_LOAD;
    item_ch.pixel_index = '0;
    item_ch.sample = '0;
    res_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Loads before any frame start widen min and max from zero.
    push_load(IDX_W'(FRAME_N - 1), -16'sd32768);
    push_load(IDX_W'(1), 16'sd32767);
    push_read(IDX_W'(FRAME_N - 1));
    push_read(IDX_W'(1));
    // Flat frame, then entries left over from before lying outside min..max.
    push_load(IDX_W'(0), 16'sd100);
    push_read(IDX_W'(0));
    push_load(IDX_W'(2), 16'sd200);
    push_read(IDX_W'(FRAME_N - 1));
    push_read(IDX_W'(1));
    push_read(IDX_W'(0));
    push_read(IDX_W'(2));
    // Full-scale frame.
    push_load(IDX_W'(0), -16'sd32768);
    push_load(IDX_W'(FRAME_N - 1), 16'sd32767);
    push_load(IDX_W'(3), 16'sd0);
    push_read(IDX_W'(0));
    push_read(IDX_W'(FRAME_N - 1));
    push_read(IDX_W'(3));
    wait_idle();

    goal = items_queued;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 5) begin
        exp_set[ph] = CFG_W'($urandom);
        ofs_set[ph] = CFG_W'($urandom);
        gain_set[ph] = CFG_W'($urandom_range(0, 1023));
      end
      cfg_write(REG_EXPOSURE, exp_set[ph]);
      cfg_write(REG_OFFSET, ofs_set[ph]);
      cfg_write(REG_GAIN, gain_set[ph]);
      goal += PHASE_ITEMS;
      while (items_queued < goal) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_frame();
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
